// ===== sv/range_min_segment_tree_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Range minimum segment tree: assertion macros
// Shared assertion macros for the segment tree RTL; they compile away when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RANGE_MIN_SEGMENT_TREE_UNIT_DEFINES_SVH
`define RANGE_MIN_SEGMENT_TREE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checked only while reset is released.
`define RMST_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define RMST_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RMST_ASSERT(name, clk, rstn, prop, msg)
`define RMST_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// ===== sv/rmst_pkg.sv =====
// ----------------------------------------------------------------------------
// Range minimum segment tree package
// Sizes, constants and the command and status types shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rmst_pkg;

    localparam int LEAF_W  = 10;
    localparam int LEAVES  = 1 << LEAF_W;
    localparam int NODE_W  = LEAF_W + 1;      // node address, 2*LEAVES nodes
    localparam int BOUND_W = NODE_W + 1;      // query bound, can reach 2*LEAVES
    localparam int VAL_W   = 32;

    localparam logic signed [VAL_W-1:0] INT_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic clr_wr;      // write the maximum value at the clearing address
        logic load;        // capture the input item
        logic upd_leaf;    // write the leaf, read its sibling
        logic upd_parent;  // write one ancestor, read the next sibling
        logic q_left;      // take the left bound node if it is odd
        logic q_right;     // take the right bound node if odd, then go up
        logic out_load;    // move the answer into the output register
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_query;
        logic in_empty;
        logic par_root;
        logic l_lt_r;
        logic out_busy;
    } t_sts;

endpackage

// ===== sv/rmst_if.sv =====
// ----------------------------------------------------------------------------
// Range minimum segment tree channel interfaces
// Valid/ready channels for input items and for query results.
// ----------------------------------------------------------------------------
interface rmst_in_if;
    import rmst_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic [LEAF_W-1:0]        leaf_index;
    logic signed [VAL_W-1:0]  new_value;
    logic [LEAF_W-1:0]        range_lo;
    logic [LEAF_W-1:0]        range_hi;

    modport source (output valid, opcode, leaf_index, new_value, range_lo, range_hi,
                    input ready);
    modport sink   (input valid, opcode, leaf_index, new_value, range_lo, range_hi,
                    output ready);
endinterface

interface rmst_out_if;
    import rmst_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  minimum;
    logic                     empty_range;

    modport source (output valid, minimum, empty_range, input ready);
    modport sink   (input valid, minimum, empty_range, output ready);
endinterface

// ===== sv/rmst_dp.sv =====
// ----------------------------------------------------------------------------
// Range minimum segment tree datapath
// Node memory, walk pointers, running minimum and the output register.
// ----------------------------------------------------------------------------
module rmst_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rmst_in_if.sink         i_in,
    rmst_out_if.source      o_res,
    input  rmst_pkg::t_cmd  i_cmd,
    output rmst_pkg::t_sts  o_sts
);
    import rmst_pkg::*;

    function automatic logic signed [VAL_W-1:0] f_min(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        f_min = (a <= b) ? a : b;
    endfunction

    logic signed [VAL_W-1:0] r_mem [2*LEAVES];
    logic signed [VAL_W-1:0] r_rdata;

    logic [NODE_W-1:0]       r_clr_addr;
    logic [NODE_W-1:0]       r_p;
    logic signed [VAL_W-1:0] r_cur;
    logic [BOUND_W-1:0]      r_l;
    logic [BOUND_W-1:0]      r_r;
    logic signed [VAL_W-1:0] r_acc;
    logic                    r_acc_pend;
    logic                    r_empty;

    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_min;
    logic                    r_out_empty;

    logic                    w_we;
    logic [NODE_W-1:0]       w_waddr;
    logic signed [VAL_W-1:0] w_wdata;
    logic [NODE_W-1:0]       w_raddr;
    logic [NODE_W-1:0]       w_parent;
    logic signed [VAL_W-1:0] w_par_min;
    logic [BOUND_W-1:0]      w_r_dec;

    assign w_parent  = {1'b0, r_p[NODE_W-1:1]};
    assign w_par_min = f_min(r_cur, r_rdata);
    assign w_r_dec   = r_r - {{(BOUND_W-1){1'b0}}, 1'b1};

    // Write port: clearing pass, leaf write or ancestor write.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr_addr;
        w_wdata = INT_MAX;
        if (i_cmd.clr_wr) begin
            w_we = 1'b1;
        end else if (i_cmd.upd_leaf) begin
            w_we    = 1'b1;
            w_waddr = r_p;
            w_wdata = r_cur;
        end else if (i_cmd.upd_parent) begin
            w_we    = 1'b1;
            w_waddr = w_parent;
            w_wdata = w_par_min;
        end
    end

    // Read port: sibling on the update path, bound nodes on the query path.
    always_comb begin
        w_raddr = r_l[NODE_W-1:0];
        if (i_cmd.upd_leaf) begin
            w_raddr = r_p ^ {{(NODE_W-1){1'b0}}, 1'b1};
        end else if (i_cmd.upd_parent) begin
            w_raddr = w_parent ^ {{(NODE_W-1){1'b0}}, 1'b1};
        end else if (i_cmd.q_right) begin
            w_raddr = w_r_dec[NODE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + {{(NODE_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_pend <= 1'b0;
        end else begin
            r_acc_pend <= (i_cmd.q_left && r_l[0]) || (i_cmd.q_right && r_r[0]);
        end
    end

    // Walk registers. A read for the query lands in the next cycle and is
    // folded into the running minimum then.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p     <= {1'b1, i_in.leaf_index};
            r_cur   <= i_in.new_value;
            r_l     <= {2'b01, i_in.range_lo};
            r_r     <= {2'b01, i_in.range_hi} + {{(BOUND_W-1){1'b0}}, 1'b1};
            r_acc   <= INT_MAX;
            r_empty <= (i_in.range_lo > i_in.range_hi);
        end else begin
            if (i_cmd.upd_parent) begin
                r_p   <= w_parent;
                r_cur <= w_par_min;
            end
            if (i_cmd.q_left) begin
                r_l <= r_l + {{(BOUND_W-1){1'b0}}, r_l[0]};
            end
            if (i_cmd.q_right) begin
                r_l <= {1'b0, r_l[BOUND_W-1:1]};
                r_r <= r_r[0] ? {1'b0, w_r_dec[BOUND_W-1:1]} : {1'b0, r_r[BOUND_W-1:1]};
            end
            if (r_acc_pend) begin
                r_acc <= f_min(r_acc, r_rdata);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_min   <= r_acc;
            r_out_empty <= r_empty;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.minimum     = r_out_min;
    assign o_res.empty_range = r_out_empty;

    always_comb begin
        o_sts.clr_last = &r_clr_addr;
        o_sts.in_query = (i_in.opcode == OP_QUERY);
        o_sts.in_empty = (i_in.range_lo > i_in.range_hi);
        o_sts.par_root = (r_p[NODE_W-1:1] == {{(NODE_W-2){1'b0}}, 1'b1});
        o_sts.l_lt_r   = (r_l < r_r);
        o_sts.out_busy = r_out_valid && !o_res.ready;
    end

endmodule

// ===== sv/rmst_ctrl.sv =====
// ----------------------------------------------------------------------------
// Range minimum segment tree controller
// Sequences the clearing pass, the leaf-to-root update walk and the
// bottom-up query walk.
// ----------------------------------------------------------------------------
`include "range_min_segment_tree_unit_defines.svh"

module rmst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rmst_pkg::t_sts  i_sts,
    output rmst_pkg::t_cmd  o_cmd
);
    import rmst_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ULEAF,
        S_UPAR,
        S_QL,
        S_QR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_sts.in_query) begin
                        n_state = S_ULEAF;
                    end else if (i_sts.in_empty) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_QL;
                    end
                end
            end
            S_ULEAF: begin
                o_cmd.upd_leaf = 1'b1;
                n_state        = S_UPAR;
            end
            S_UPAR: begin
                o_cmd.upd_parent = 1'b1;
                if (i_sts.par_root) begin
                    n_state = S_IDLE;
                end
            end
            S_QL: begin
                // The last bound read is folded into the minimum at the edge
                // that leaves this state, so S_DONE sees the final answer.
                if (i_sts.l_lt_r) begin
                    o_cmd.q_left = 1'b1;
                    n_state      = S_QR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_QR: begin
                o_cmd.q_right = 1'b1;
                n_state       = S_QL;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `RMST_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> r_state == S_CLEAR, "no clearing pass after reset")
    `RMST_ASSERT(a_out_free, i_clk, i_rst_n, o_cmd.out_load |-> !i_sts.out_busy, "result overwrites a waiting result")
    `RMST_ASSERT(a_item_starts, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> r_state != S_IDLE, "accepted item did not start")
    `RMST_ASSERT(a_no_write_in_query, i_clk, i_rst_n, (r_state == S_QL || r_state == S_QR) |-> !(o_cmd.upd_leaf || o_cmd.upd_parent || o_cmd.clr_wr), "tree written during a query")

endmodule

// ===== sv/range_min_segment_tree_unit.sv =====
// Sequencing: an update writes the leaf and then each ancestor up to the root;
// a query walks the tree bottom-up, one level at a time, up to its result.
// Throughput: one item at a time; the single read port of the node memory makes
// each level of the query walk take a left-bound and a right-bound state. An
// empty range skips the walk. Reset: synchronous; a clearing pass then writes
// all 2*LEAVES nodes to the maximum value while no item is accepted.
// ----------------------------------------------------------------------------
// Range minimum segment tree unit
// Point updates and inclusive range-minimum queries over a tree of signed
// 32-bit leaves.
// ----------------------------------------------------------------------------
module range_min_segment_tree_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmst_in_if.sink     i_in,
    rmst_out_if.source  o_res
);
    import rmst_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready = w_in_ready;

    rmst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rmst_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_res   (o_res),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

endmodule
